/* src/joystick_to_polar_vector_core_defines.svh */
// Assertion macros for the joystick to polar vector core.
`ifndef JOYSTICK_TO_POLAR_VECTOR_CORE_DEFINES_SVH
`define JOYSTICK_TO_POLAR_VECTOR_CORE_DEFINES_SVH
// Assert that an implication holds at every clock edge outside reset.
`define JPV_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Assert that a signal is low while reset is applied.
`define JPV_ASSERT_RST(label, clk, rst_n, sig, msg) \
	label: assert property (@(posedge clk) !rst_n |-> !(sig)) else $error(msg);
`endif

/* src/jpv_pkg.sv */
// Shared types, constants and functions for the joystick to polar vector core.
`default_nettype none
package jpv_pkg;
	localparam int ANGLE_FRACTION_BITS_DEF = 14;
	localparam int ZW = 34;      // angle accumulator width
	localparam logic [7:0] SPEED_MAX_RST = 8'd127;
	localparam logic [7:0] SPEED_MIN_RST = 8'd0;
	localparam logic signed [7:0] INVALID_CODE = -8'sd128;
	localparam logic signed [8:0] INVALID_SPEED = -9'sd128;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic [28:0] RAD_TO_CODE_Q24 = 29'd320421223;

	typedef enum logic [0:0] {
		REG_SPEED_MAX = 1'b0,
		REG_SPEED_MIN = 1'b1
	} reg_idx_t;

	typedef enum logic [0:0] {
		FUNC_CART = 1'b0,
		FUNC_POLAR = 1'b1
	} func_t;

	// Side data carried down the pipeline next to the CORDIC word.
	typedef struct packed {
		logic              func;
		logic              zero;
		logic signed [7:0] pcode;
		logic [7:0]        spd;
	} side_t;

	function automatic logic signed [33:0] atan_q30(input int i);
		logic signed [33:0] r;
		case (i)
			0: r = 34'sd843314856;
			1: r = 34'sd497837829;
			2: r = 34'sd263043836;
			3: r = 34'sd133525158;
			4: r = 34'sd67021686;
			5: r = 34'sd33543515;
			6: r = 34'sd16775850;
			7: r = 34'sd8388437;
			8: r = 34'sd4194282;
			9: r = 34'sd2097149;
			10: r = 34'sd1048575;
			11: r = 34'sd524287;
			12: r = 34'sd262143;
			13: r = 34'sd131071;
			14: r = 34'sd65535;
			15: r = 34'sd32767;
			16: r = 34'sd16383;
			17: r = 34'sd8191;
			18: r = 34'sd4095;
			19: r = 34'sd2047;
			20: r = 34'sd1023;
			21: r = 34'sd511;
			22: r = 34'sd255;
			23: r = 34'sd127;
			24: r = 34'sd63;
			25: r = 34'sd31;
			26: r = 34'sd15;
			27: r = 34'sd7;
			28: r = 34'sd3;
			29: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

/* src/jpv_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module jpv_isqrt import jpv_pkg::*; (
	input  wire logic        clk,
	input  wire logic [7:0]  en,
	input  wire logic [15:0] sq,
	output logic [7:0]       root
);
	// Trial-squaring square root: stage k decides bit 7-k. 16-bit radicand, 8-bit root.
	logic [15:0] rem_s [0:8];
	logic [7:0]  r_s   [0:8];

	assign rem_s[0] = sq;
	assign r_s[0]   = 8'd0;

	for (genvar k = 0; k < 8; k++) begin : g_st
		logic [7:0]  t;
		logic [15:0] tt;
		assign t  = r_s[k] | (8'd1 << (7 - k));
		assign tt = 16'(t) * 16'(t);
		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k+1] <= rem_s[k];
				r_s[k+1]   <= (tt <= rem_s[k]) ? t : r_s[k];
			end
		end
	end

	assign root = r_s[8];
endmodule
`default_nettype wire

/* src/joystick_to_polar_vector_core.sv */
// Top level: pipelined joystick to polar vector conversion (CORDIC angle, square-root speed).
// Throughput: one beat per cycle unless the output stalls; one CORDIC iteration and one root bit per stage.
// A full output stage with a stalled consumer backs pressure through the run of full stages behind it.
// Reset (arst_n low, asynchronous) empties all stages and sets speed limits to 127 / 0.
`default_nettype none
`include "joystick_to_polar_vector_core_defines.svh"
module joystick_to_polar_vector_core import jpv_pkg::*; #(
	parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              func,
	input  wire logic signed [7:0] x_axis,
	input  wire logic signed [7:0] y_axis,
	input  wire logic signed [8:0] angle_degrees,
	input  wire logic [7:0]        polar_length,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [7:0]      angle_code,
	output logic signed [8:0]      speed,
	output logic                   valid_res,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [7:0]        cfg_data
);
	localparam int F  = ANGLE_FRACTION_BITS;
	localparam int AW = F + 11;         // CORDIC word: 181 * gain * 2^F plus sign and margin
	localparam int NI = F + 1;          // CORDIC iterations
	localparam int NS = NI + 4;         // total stages
	localparam int SQ = 1;              // first stage of the square root

	// Speed limit registers.
	logic [7:0] smax_q, smin_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smax_q <= SPEED_MAX_RST;
			smin_q <= SPEED_MIN_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SPEED_MAX: smax_q <= cfg_data;
				REG_SPEED_MIN: smin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stall control: each stage advances when downstream has room.
	logic [NS:1] v_s;
	logic [NS:0] adv;
	assign adv[NS] = !v_s[NS] || out_ready;
	for (genvar k = NS - 1; k >= 0; k--) begin : g_adv
		assign adv[k] = !v_s[k+1] || adv[k+1];
	end
	assign in_ready = adv[0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (adv[0]) v_s[1] <= in_valid;
			for (int k = 1; k < NS; k++)
				if (adv[k]) v_s[k+1] <= v_s[k];
		end
	end

	// Stage 1: prescale, quadrant turn, squares, polar divide by three.
	logic signed [AW-1:0] xs_s [1:NI+1];
	logic signed [AW-1:0] ys_s [1:NI+1];
	logic signed [ZW-1:0] z_s  [1:NI+1];
	side_t                sd_s [1:NS-1];
	logic [15:0]          sq_s1;

	logic signed [AW-1:0] sx, sy;
	logic [8:0]           amag;
	logic [17:0]          aprod;
	logic [7:0]           aq;
	logic signed [7:0]    a3;
	logic [15:0]          sqsum;
	assign sx = AW'(x_axis) <<< F;
	assign sy = AW'(y_axis) <<< F;
	// Divide the magnitude by three: 171/512 is exact for magnitudes up to 256.
	assign amag  = angle_degrees[8] ? 9'(-angle_degrees) : 9'(angle_degrees);
	assign aprod = 18'(amag) * 18'd171;
	assign aq    = aprod[16:9];
	assign a3    = angle_degrees[8] ? -$signed(aq) : $signed(aq);
	assign sqsum = 16'(x_axis * x_axis) + 16'(y_axis * y_axis);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			sd_s[1].func  <= func;
			sd_s[1].zero  <= (x_axis == 8'sd0) && (y_axis == 8'sd0);
			sd_s[1].pcode <= a3;
			sd_s[1].spd   <= polar_length;
			sq_s1         <= sqsum;
			if (y_axis < 0) begin
				if (x_axis >= 0) begin
					ys_s[1] <= sx;
					xs_s[1] <= -sy;
					z_s[1]  <= HALF_PI_Q30 >>> (30 - F);
				end else begin
					ys_s[1] <= -sx;
					xs_s[1] <= sy;
					z_s[1]  <= -(HALF_PI_Q30 >>> (30 - F));
				end
			end else begin
				xs_s[1] <= sx;
				ys_s[1] <= sy;
				z_s[1]  <= '0;
			end
		end
	end

	// CORDIC vectoring stages, one iteration each.
	for (genvar i = 0; i < NI; i++) begin : g_cordic
		logic signed [ZW-1:0] a;
		assign a = atan_q30(i) >>> (30 - F);
		always_ff @(posedge clk) begin
			if (adv[i+1]) begin
				if (xs_s[i+1] >= 0) begin
					ys_s[i+2] <= ys_s[i+1] + (xs_s[i+1] >>> i);
					xs_s[i+2] <= xs_s[i+1] - (ys_s[i+1] >>> i);
					z_s[i+2]  <= z_s[i+1] + a;
				end else begin
					ys_s[i+2] <= ys_s[i+1] - (xs_s[i+1] >>> i);
					xs_s[i+2] <= xs_s[i+1] + (ys_s[i+1] >>> i);
					z_s[i+2]  <= z_s[i+1] - a;
				end
			end
		end
	end

	// Side data rides alongside.
	for (genvar k = 1; k < NS - 1; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv[k]) sd_s[k+1] <= sd_s[k];
		end
	end

	// Square root over eight stages from stage 1.
	logic [7:0] root;
	jpv_isqrt u_isqrt (
		.clk    (clk),
		.en     (adv[SQ +: 8]),
		.sq     (sq_s1),
		.root   (root)
	);
	// Hold the root until the CORDIC catches up.
	logic [7:0] rt_s [SQ+8:NS-1];
	assign rt_s[SQ+8] = root;
	for (genvar k = SQ + 8; k < NS - 1; k++) begin : g_rt
		always_ff @(posedge clk) begin
			if (adv[k]) rt_s[k+1] <= rt_s[k];
		end
	end

	// Angle to code: magnitude, multiply, round, clamp.
	localparam int PI_ST = NI + 1;
	logic [ZW-1:0]  zmag;
	logic           zneg_s;
	logic [62:0]    prod_s;
	logic [7:0]     code_s;
	logic           cneg_s;
	assign zmag = z_s[PI_ST][ZW-1] ? ZW'(-z_s[PI_ST]) : ZW'(z_s[PI_ST]);
	always_ff @(posedge clk) begin
		if (adv[PI_ST]) begin
			zneg_s <= z_s[PI_ST][ZW-1];
			prod_s <= 63'(zmag) * 63'(RAD_TO_CODE_Q24);
		end
	end
	logic [62:0] rnd;
	assign rnd = (prod_s + (63'd1 << (F + 23))) >> (F + 24);
	always_ff @(posedge clk) begin
		if (adv[PI_ST+1]) begin
			cneg_s <= zneg_s;
			code_s <= (rnd > 63'd60) ? 8'd60 : rnd[7:0];
		end
	end

	// Final stage: select mode, check limits, register result.
	logic signed [7:0] cd;
	logic [7:0]        sp;
	side_t             sf;
	assign sf = sd_s[NS-1];
	always_comb begin
		if (sf.func == FUNC_POLAR) begin
			cd = sf.pcode;
			sp = sf.spd;
		end else begin
			sp = rt_s[NS-1];
			cd = sf.zero ? 8'sd0 : (cneg_s ? -$signed(code_s) : $signed(code_s));
		end
	end
	always_ff @(posedge clk) begin
		if (adv[NS-1]) begin
			if (sp > smax_q || sp < smin_q) begin
				angle_code <= INVALID_CODE;
				speed      <= INVALID_SPEED;
				valid_res  <= 1'b0;
			end else begin
				angle_code <= cd;
				speed      <= $signed({1'b0, sp});
				valid_res  <= 1'b1;
			end
		end
	end
	assign out_valid = v_s[NS];

	logic inv_vec;
	assign inv_vec = (speed == INVALID_SPEED) && (angle_code == INVALID_CODE);

	// Flag a stall that leaves the output side without back pressure.
	`JPV_ASSERT_IMPL(a_hold, clk, arst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
	`JPV_ASSERT_IMPL(a_inv, clk, arst_n, (out_valid && !valid_res) |-> inv_vec, "bad invalid vector")
	`JPV_ASSERT_RST(a_rst, clk, arst_n, out_valid, "valid during reset")
endmodule
`default_nettype wire

/* tb/tb_joystick_to_polar_vector_core.sv */
// Random and directed check of the joystick to polar vector core against its own predictor.
`default_nettype none
import jpv_pkg::*;

class polar_scoreboard;
	typedef struct packed {
		logic signed [7:0] code;
		logic signed [8:0] spd;
		logic              ok;
	} vec_t;

	vec_t pending[$];
	int   mismatches;
	logic [7:0] lim_max;
	logic [7:0] lim_min;

	function new();
		mismatches = 0;
		lim_max = SPEED_MAX_RST;
		lim_min = SPEED_MIN_RST;
	endfunction

	// Exact floor square root, one result bit per pass.
	static function int root_floor(int s);
		int r;
		int t;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			t = r | (1 << b);
			if (t * t <= s)
				r = t;
		end
		return r;
	endfunction

	// Vectoring CORDIC on the stick pair, then scale radians to 3-degree steps.
	static function int stick_heading(longint x, longint y);
		int unsigned    fb;
		longint         sd, fw, z, tmp, step, ds, df, p, mag, c;
		longint         tbl[31];
		fb = 14;
		tbl = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
			16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
			131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
			127, 63, 31, 15, 7, 3, 1, 0};
		if (x == 0 && y == 0)
			return 0;
		sd = x <<< fb;
		fw = y <<< fb;
		z = 0;
		if (fw < 0) begin
			tmp = fw;
			if (sd >= 0) begin
				fw = sd;
				sd = -tmp;
				z = 64'sd1686629713 >>> (30 - fb);
			end else begin
				fw = -sd;
				sd = tmp;
				z = -(64'sd1686629713 >>> (30 - fb));
			end
		end
		for (int i = 0; i <= fb; i++) begin
			step = tbl[i] >>> (30 - fb);
			ds = sd >>> i;
			df = fw >>> i;
			if (sd >= 0) begin
				fw = fw + ds;
				sd = sd - df;
				z += step;
			end else begin
				fw = fw - ds;
				sd = sd + df;
				z -= step;
			end
		end
		p = z * 64'sd320421223;
		mag = p < 0 ? -p : p;
		c = (mag + (64'sd1 <<< (fb + 23))) >>> (fb + 24);
		if (c > 60)
			c = 60;
		return int'(p < 0 ? -c : c);
	endfunction

	function void note_input(logic fn, logic signed [7:0] x, logic signed [7:0] y,
			logic signed [8:0] ang, logic [7:0] len);
		vec_t v;
		int   c;
		int   s;
		if (fn == FUNC_CART) begin
			s = root_floor(int'(x) * int'(x) + int'(y) * int'(y));
			c = stick_heading(longint'(x), longint'(y));
		end else begin
			c = int'(ang) / 3;
			s = int'(len);
		end
		if (s > int'(lim_max) || s < int'(lim_min)) begin
			v.code = INVALID_CODE;
			v.spd = INVALID_SPEED;
			v.ok = 1'b0;
		end else begin
			v.code = c[7:0];
			v.spd = s[8:0];
			v.ok = 1'b1;
		end
		pending.push_back(v);
	endfunction

	function void check_result(logic signed [7:0] code, logic signed [8:0] spd, logic ok);
		vec_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result code=%0d speed=%0d valid=%0b", code, spd, ok);
			return;
		end
		e = pending.pop_front();
		if (e.code !== code || e.spd !== spd || e.ok !== ok) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp code=%0d speed=%0d valid=%0b got code=%0d speed=%0d valid=%0b",
					e.code, e.spd, e.ok, code, spd, ok);
		end
	endfunction
endclass

module tb_joystick_to_polar_vector_core;
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              func;
	logic signed [7:0] x_axis;
	logic signed [7:0] y_axis;
	logic signed [8:0] angle_degrees;
	logic [7:0]        polar_length;
	logic              out_valid;
	logic              out_ready;
	logic signed [7:0] angle_code;
	logic signed [8:0] speed;
	logic              valid_res;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [0:0]        cfg_index;
	logic [7:0]        cfg_data;

	polar_scoreboard vectors;
	longint          cycles;
	bit              drain_active;
	localparam longint CYCLE_LIMIT = 400000;

	joystick_to_polar_vector_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .x_axis(x_axis), .y_axis(y_axis),
		.angle_degrees(angle_degrees), .polar_length(polar_length),
		.out_valid(out_valid), .out_ready(out_ready),
		.angle_code(angle_code), .speed(speed), .valid_res(valid_res),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Timeout watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_joystick_to_polar_vector_core: errors");
			$finish;
		end
	end

	// Result side: check every accepted beat, stall at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			vectors.check_result(angle_code, speed, valid_res);
	end

	initial begin
		int g;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			g = drain_active ? 0 : pick_gap();
			if (g == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (g - 1) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// Send one beat, holding payload until accepted.
	task automatic send_beat(logic fn, logic signed [7:0] x, logic signed [7:0] y,
			logic signed [8:0] ang, logic [7:0] len, bit allow_gap);
		int g;
		g = allow_gap ? pick_gap() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= fn;
		x_axis <= x;
		y_axis <= y;
		angle_degrees <= ang;
		polar_length <= len;
		do @(posedge clk); while (!in_ready);
		vectors.note_input(fn, x, y, ang, len);
	endtask

	task automatic send_stick(logic signed [7:0] x, logic signed [7:0] y);
		send_beat(FUNC_CART, x, y, 9'($urandom), 8'($urandom), 1'b1);
	endtask

	task automatic send_polar(logic signed [8:0] ang, logic [7:0] len);
		send_beat(FUNC_POLAR, 8'($urandom), 8'($urandom), ang, len, 1'b1);
	endtask

	// Drain: lower valid, wait until every expectation has come back, then let
	// the pipeline settle before touching the limits.
	task automatic drain_all();
		in_valid <= 1'b0;
		@(posedge clk);
		while (vectors.pending.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Write one limit, then idle the channel.
	task automatic write_limit(reg_idx_t idx, logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_SPEED_MAX)
			vectors.lim_max = val;
		else
			vectors.lim_min = val;
		@(posedge clk);
	endtask

	task automatic random_phase(int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				send_stick(8'($urandom), 8'($urandom));
			else if (r < 7)
				send_stick(8'($urandom_range(0, 6) - 3), 8'($urandom_range(0, 6) - 3));
			else if (r < 9)
				send_polar(9'($urandom_range(0, 360) - 180), 8'($urandom_range(0, 181)));
			else
				send_polar(9'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		vectors = new();
		cycles = 0;
		drain_active = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_CART;
		x_axis = '0;
		y_axis = '0;
		angle_degrees = '0;
		polar_length = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SPEED_MAX;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset limits, stick extremes, centered stick, straight back, polar edge cases.
		send_stick(8'sd0, 8'sd0);
		send_stick(8'sd0, -8'sd100);
		send_stick(8'sd0, 8'sd127);
		send_stick(8'sd127, 8'sd0);
		send_stick(-8'sd128, 8'sd0);
		send_stick(-8'sd128, -8'sd128);
		send_stick(8'sd127, 8'sd127);
		send_stick(8'sd90, -8'sd90);
		send_stick(-8'sd1, -8'sd1);
		send_stick(8'sd1, -8'sd128);
		send_polar(9'sd180, 8'd127);
		send_polar(-9'sd180, 8'd128);
		send_polar(-9'sd256, 8'd0);
		send_polar(9'sd255, 8'd255);
		send_polar(-9'sd4, 8'd50);
		send_polar(9'sd5, 8'd181);
		drain_all();

		// Widest window, including sqrt(2)*128.
		write_limit(REG_SPEED_MAX, 8'd255);
		write_limit(REG_SPEED_MIN, 8'd0);
		send_stick(-8'sd128, -8'sd128);
		send_polar(-9'sd1, 8'd255);
		random_phase(150);
		drain_all();

		// Minimum above maximum: all beats invalid.
		write_limit(REG_SPEED_MAX, 8'd20);
		write_limit(REG_SPEED_MIN, 8'd181);
		random_phase(40);
		drain_all();

		// Narrow window around mid speeds.
		write_limit(REG_SPEED_MAX, 8'd100);
		write_limit(REG_SPEED_MIN, 8'd40);
		random_phase(120);
		drain_all();

		// Zero-only window, then a window of 1 to 181.
		write_limit(REG_SPEED_MAX, 8'd0);
		write_limit(REG_SPEED_MIN, 8'd0);
		send_stick(8'sd0, 8'sd0);
		random_phase(30);
		drain_all();
		write_limit(REG_SPEED_MAX, 8'd181);
		write_limit(REG_SPEED_MIN, 8'd1);
		random_phase(110);

		drain_active = 1;
		drain_all();
		if (vectors.mismatches == 0 && vectors.pending.size() == 0)
			$display("tb_joystick_to_polar_vector_core: clean");
		else
			$display("tb_joystick_to_polar_vector_core: errors");
		$finish;
	end
endmodule
`default_nettype wire
